/* sv/fmv_pkg.sv */
// Shared constants and codes for the FRU mailbox with record validator.
package fmv_pkg;

  localparam int STORE_BYTES = 256;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int AREA_LIMIT  = STORE_BYTES - 8;
  localparam int FIELD_LIMIT = STORE_BYTES - 3;

  localparam logic [5:0] LEN_MASK = 6'h3F;

  typedef enum logic [1:0] {
    CMD_OP_WRITE   = 2'd0,
    CMD_DATA_WRITE = 2'd1,
    CMD_DATA_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    OP_CLI_OVERRIDE = 3'd0,
    OP_CLI_IDLE     = 3'd1,
    OP_GET_OFFSET   = 3'd2,
    OP_READ         = 3'd3,
    OP_SET_OFFSET   = 3'd4,
    OP_WRITE        = 3'd5,
    OP_COMMIT       = 3'd6
  } op_t;

  localparam logic [3:0] OP_COUNT = 4'd7;

  localparam logic [2:0] BOARD_FIELDS   = 3'd4;
  localparam logic [2:0] PRODUCT_FIELDS = 3'd6;

endpackage

/* sv/fru_mailbox_with_validator.sv */
// FRU mailbox: host register access to a byte store with record check on commit.
//
// Usage:
//   Input channel s_*: one beat per host access. s_tuser selects the access
//   (0 op register write, 1 data register write, 2 data register read).
//   s_tdata carries the requested op (bits 3:0) and the data value (35:4).
//   Output channel m_*: one beat per access with status, data register and
//   current op. The result sits in an output register, so the next access is
//   taken while a result still waits for m_tready.
// Sequence: simple register accesses go straight to the result; a byte read
//   first fetches the byte. Entering read reloads the working store from the
//   committed store, a copy sweep through one memory port each side. A commit walks
//   the header, both areas and the field chain through one byte fetch unit, then
//   copies the working store into the committed store, or on a failure reloads the working store.
//   One access is worked on at a time; s_tready is high only when idle.
// Reset: rst clears the control state and then runs a clearing pass that
//   zeroes both stores; no access is accepted during that pass.
// Stall: a result not taken holds m_tdata; a finished access waits in its
//   final state until the output register frees up.
module fru_mailbox_with_validator
  import fmv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // new_op[3:0], data[35:4], zero fill
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[0], data_reg[8:1], current_op[11:9], zero fill
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_WAIT, S_RDBYTE, S_COPY, S_DONE,
    S_HDR, S_AREA, S_AREA_VER, S_AREA_LEN, S_SUM, S_FLD_START, S_FLD, S_FAIL
  } state_t;

  state_t         state, ret;
  logic [7:0]     work_mem   [STORE_BYTES];
  logic [7:0]     commit_mem [STORE_BYTES];
  logic [7:0]     work_rd, commit_rd;
  logic [AW-1:0]  addr, rd_addr;
  logic [AW:0]    cnt, len_reg, pos;
  logic [AW-1:0]  ptr;
  op_t            op_reg;
  logic [7:0]     data_reg;
  logic           res_err, bad, area, to_commit, then_read;
  logic [7:0]     sum, b3, b4;
  logic [10:0]    base;
  logic [2:0]     k;

  // memory write ports
  logic           w_we, c_we;
  logic [AW-1:0]  w_wa, c_wa;
  logic [7:0]     w_wd, c_wd;
  logic           dwrite;

  cmd_t           cmd;
  logic [3:0]     req;
  logic [31:0]    val;

  // combinational helpers
  logic [7:0]     sum_n;
  logic [10:0]    len8;
  logic [11:0]    area_end;
  logic [5:0]     fl;
  logic [AW+1:0]  fend;
  logic [AW:0]    pos_n;
  logic [2:0]     fcount;

  assign cmd = cmd_t'(s_tuser);
  assign req = s_tdata[3:0];
  assign val = s_tdata[35:4];

  assign s_tready = (state == S_IDLE);
  assign rd_addr  = (state == S_COPY) ? cnt[AW-1:0] : addr;
  assign dwrite   = s_tvalid && s_tready && (cmd == CMD_DATA_WRITE) && (op_reg == OP_WRITE);

  assign sum_n    = sum + work_rd;
  assign len8     = {work_rd, 3'b000};
  assign area_end = {1'b0, base} + {1'b0, len8};
  assign fl       = work_rd[5:0] & LEN_MASK;
  assign fend     = {1'b0, pos} + (AW+2)'(fl);
  assign pos_n    = pos + (AW+1)'(fl) + (AW+1)'(1);
  assign fcount   = area ? PRODUCT_FIELDS : BOARD_FIELDS;

  always_comb begin
    w_we = 1'b0;
    w_wa = cnt[AW-1:0];
    w_wd = 8'd0;
    c_we = 1'b0;
    c_wa = cnt[AW-1:0];
    c_wd = 8'd0;
    if (state == S_CLEAR) begin
      w_we = 1'b1;
      c_we = 1'b1;
    end else if (state == S_COPY && cnt != '0) begin
      w_wa = AW'(cnt - 1'b1);
      c_wa = AW'(cnt - 1'b1);
      w_wd = commit_rd;
      c_wd = work_rd;
      w_we = !to_commit;
      c_we = to_commit;
    end else if (dwrite) begin
      w_we = 1'b1;
      w_wa = ptr;
      w_wd = val[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) work_mem[w_wa] <= w_wd;
    work_rd <= work_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (c_we) commit_mem[c_wa] <= c_wd;
    commit_rd <= commit_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ret       <= S_IDLE;
      cnt       <= '0;
      ptr       <= '0;
      op_reg    <= OP_CLI_IDLE;
      data_reg  <= 8'd0;
      m_tvalid  <= 1'b0;
      res_err   <= 1'b0;
      to_commit <= 1'b0;
      then_read <= 1'b0;
    end else begin
      // S_DONE drives m_tvalid itself
      if (m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == (AW+1)'(STORE_BYTES - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            res_err <= 1'b0;
            state   <= S_DONE;
            case (cmd)
              CMD_OP_WRITE: begin
                if (req >= OP_COUNT || op_reg == OP_CLI_OVERRIDE) begin
                  res_err <= 1'b1;
                end else begin
                  case (op_t'(req[2:0]))
                    OP_GET_OFFSET: begin
                      data_reg <= 8'(ptr);
                      op_reg   <= OP_GET_OFFSET;
                    end
                    OP_READ: begin
                      op_reg <= OP_READ;
                      if (op_reg != OP_READ) begin
                        cnt       <= '0;
                        to_commit <= 1'b0;
                        then_read <= 1'b1;
                        state     <= S_COPY;
                      end else begin
                        addr  <= ptr;
                        ret   <= S_RDBYTE;
                        state <= S_WAIT;
                      end
                    end
                    OP_SET_OFFSET: op_reg <= OP_SET_OFFSET;
                    OP_WRITE: begin
                      if (op_reg inside {OP_SET_OFFSET, OP_WRITE}) op_reg <= OP_WRITE;
                      else res_err <= 1'b1;
                    end
                    OP_COMMIT: begin
                      ptr <= '0;
                      if (op_reg == OP_WRITE) begin
                        cnt   <= '0;
                        sum   <= 8'd0;
                        bad   <= 1'b0;
                        addr  <= '0;
                        ret   <= S_HDR;
                        state <= S_WAIT;
                      end else if (op_reg != OP_COMMIT) begin
                        res_err <= 1'b1;
                      end
                    end
                    default: res_err <= 1'b1;  // console-only ops
                  endcase
                end
              end
              CMD_DATA_WRITE: begin
                if (op_reg == OP_SET_OFFSET) begin
                  if (val >= 32'(STORE_BYTES)) res_err <= 1'b1;
                  else ptr <= val[AW-1:0];
                end else if (op_reg == OP_WRITE) begin
                  ptr <= ptr + 1'b1;
                end else begin
                  res_err <= 1'b1;
                end
              end
              CMD_DATA_READ: begin
                if (op_reg == OP_READ) begin
                  addr  <= ptr;
                  ret   <= S_RDBYTE;
                  state <= S_WAIT;
                end else if (op_reg != OP_GET_OFFSET) begin
                  res_err <= 1'b1;
                end
              end
              default: res_err <= 1'b1;
            endcase
          end
        end
        S_WAIT: state <= ret;
        S_RDBYTE: begin
          data_reg <= work_rd;
          ptr      <= ptr + 1'b1;
          state    <= S_DONE;
        end
        S_COPY: begin
          cnt <= cnt + 1'b1;
          if (cnt == (AW+1)'(STORE_BYTES)) begin
            cnt <= '0;
            if (then_read) begin
              then_read <= 1'b0;
              addr      <= ptr;
              ret       <= S_RDBYTE;
              state     <= S_WAIT;
            end else begin
              state <= S_DONE;
            end
          end
        end
        // common header, bytes 0..7
        S_HDR: begin
          sum <= sum_n;
          if (cnt == 'd0 && work_rd != 8'd1) bad <= 1'b1;
          if (cnt == 'd3) b3 <= work_rd;
          if (cnt == 'd4) b4 <= work_rd;
          if (cnt == 'd6 && work_rd != 8'd0) bad <= 1'b1;
          if (cnt == 'd7) begin
            if (bad || sum_n != 8'd0) begin
              state <= S_FAIL;
            end else begin
              area  <= 1'b0;
              base  <= {b3, 3'b000};
              state <= S_AREA;
            end
          end else begin
            cnt   <= cnt + 1'b1;
            addr  <= AW'(cnt + 1'b1);
            state <= S_WAIT;
          end
        end
        S_AREA: begin
          if (base > 11'(AREA_LIMIT)) begin
            state <= S_FAIL;
          end else begin
            addr  <= base[AW-1:0];
            ret   <= S_AREA_VER;
            state <= S_WAIT;
          end
        end
        S_AREA_VER: begin
          if (work_rd != 8'd1) begin
            state <= S_FAIL;
          end else begin
            addr  <= AW'(base + 11'd1);
            ret   <= S_AREA_LEN;
            state <= S_WAIT;
          end
        end
        S_AREA_LEN: begin
          if (area_end > 12'(STORE_BYTES)) begin
            state <= S_FAIL;
          end else if (len8 == 11'd0) begin
            state <= S_FLD_START;
          end else begin
            len_reg <= (AW+1)'(len8);
            sum     <= 8'd0;
            cnt     <= '0;
            addr    <= base[AW-1:0];
            ret     <= S_SUM;
            state   <= S_WAIT;
          end
        end
        S_SUM: begin
          sum <= sum_n;
          if (cnt == len_reg - 1'b1) begin
            cnt   <= '0;
            state <= (sum_n != 8'd0) ? S_FAIL : S_FLD_START;
          end else begin
            cnt   <= cnt + 1'b1;
            addr  <= AW'(base + 11'(cnt) + 11'd1);
            state <= S_WAIT;
          end
        end
        S_FLD_START: begin
          pos   <= (AW+1)'(base + (area ? 11'd3 : 11'd6));
          addr  <= AW'(base + (area ? 11'd3 : 11'd6));
          k     <= 3'd0;
          ret   <= S_FLD;
          state <= S_WAIT;
        end
        // type/length chain: each field skips L+1 bytes, a length of one fails the check
        S_FLD: begin
          if (fend >= (AW+2)'(FIELD_LIMIT) || fl == 6'd1) begin
            state <= S_FAIL;
          end else if (k == fcount - 1'b1) begin
            if (!area) begin
              area  <= 1'b1;
              base  <= {b4, 3'b000};
              state <= S_AREA;
            end else begin
              op_reg    <= OP_COMMIT;
              cnt       <= '0;
              to_commit <= 1'b1;
              state     <= S_COPY;
            end
          end else begin
            k     <= k + 1'b1;
            pos   <= pos_n;
            addr  <= pos_n[AW-1:0];
            state <= S_WAIT;
          end
        end
        S_FAIL: begin
          res_err   <= 1'b1;
          cnt       <= '0;
          to_commit <= 1'b0;
          then_read <= 1'b0;
          state     <= S_COPY;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, op_reg, data_reg, res_err};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // one access at a time: an accepted beat takes the block out of idle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a beat while busy");

  // the console override op is never entered from the host side
  a_no_override: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> op_reg != OP_CLI_OVERRIDE)
    else $error("op register reached console override");

  // a passing commit always restarts the pointer
  a_commit_ptr: assert property (@(posedge clk) disable iff (rst)
    $rose(op_reg == OP_COMMIT) |-> ptr == '0)
    else $error("pointer not cleared on commit");

  // the copy sweep never runs past the store
  a_copy_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_COPY |-> cnt <= (AW+1)'(STORE_BYTES))
    else $error("copy counter overran store");
`endif

endmodule
